@@ src/wfba_pkg.sv @@
// Package for the worst-fit block allocator.
// Holds field widths, result status codes and sequencer states.
// No dependencies.
`default_nettype none

package wfba_pkg;

  // Extent size field width (block counts up to 131071).
  localparam int SIZE_W = 17;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_NO_REGION     = 3'd1,
    ST_OUT_OF_MEMORY = 3'd2,
    ST_TABLE_FULL    = 3'd3,
    ST_BAD_REQUEST   = 3'd4
  } result_code_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HEAD,
    S_INS,
    S_CMP,
    S_PUT,
    S_DONE
  } seq_state_t;

endpackage

`default_nettype wire

@@ src/worst_fit_block_allocator_core.sv @@
// Worst-fit block allocator: sorted free-extent table kept in a circular memory.
// Depends on wfba_pkg and wfba_extent_ram.
//
//   channel | direction | ports                                          | handshake
//   in      | input     | in_action, in_block_count, in_start_block      | in_valid / in_stall
//   out     | output    | out_status, out_region_start, out_region_blocks| out_valid / out_stall
//
// One word at a time. An add walks S_INS/S_CMP, moving entries not larger than the new
// one down a slot, then writes it in S_PUT, or straight in S_INS into an empty table;
// an allocate first reads the head in S_HEAD. A rejected word goes straight to S_DONE, a
// failed allocate via S_HEAD. Entries move one at a time through the single write port.
// Reset (synchronous, rst_n low) empties the table; the memory is not cleared.
// A finished result waits in the output register while the next word is taken.
`default_nettype none

module worst_fit_block_allocator_core #(
  parameter int MAX_FREE_EXTENTS = 16,
  parameter int BLOCK_INDEX_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,

  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_action,
  input  wire logic [wfba_pkg::SIZE_W-1:0]   in_block_count,
  input  wire logic [BLOCK_INDEX_BITS-1:0]   in_start_block,

  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [2:0]                    out_status,
  output logic      [BLOCK_INDEX_BITS-1:0]   out_region_start,
  output logic      [wfba_pkg::SIZE_W-1:0]   out_region_blocks
);

  localparam int SW    = wfba_pkg::SIZE_W;
  localparam int BW    = BLOCK_INDEX_BITS;
  localparam int PTR_W = $clog2(MAX_FREE_EXTENTS);
  localparam int CNT_W = $clog2(MAX_FREE_EXTENTS + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam int ENT_W = BW + SW;
  localparam int ADD_W = (BW > SW) ? BW : SW;

  // Logical slot (0 = head) to physical address in the circular buffer.
  function automatic logic [PTR_W-1:0] phys(input logic [PTR_W-1:0] head,
                                            input logic [CNT_W-1:0] slot);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(head) + SUM_W'(slot);
    if (sum >= SUM_W'(MAX_FREE_EXTENTS)) begin
      sum = sum - SUM_W'(MAX_FREE_EXTENTS);
    end
    return sum[PTR_W-1:0];
  endfunction

  wfba_pkg::seq_state_t state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [SW-1:0]    req_r, req_nxt;
  logic [BW-1:0]    new_start_r, new_start_nxt;
  logic [SW-1:0]    new_size_r, new_size_nxt;

  wfba_pkg::result_code_t res_status_r, res_status_nxt;
  logic [BW-1:0]     res_start_r, res_start_nxt;
  logic [SW-1:0]     res_blocks_r, res_blocks_nxt;

  logic                   out_valid_r;
  wfba_pkg::result_code_t out_status_r;
  logic [BW-1:0]          out_region_start_r;
  logic [SW-1:0]          out_region_blocks_r;
  logic                   load_out;

  logic             wr_en, rd_en;
  logic [PTR_W-1:0] wr_addr, rd_addr;
  logic [ENT_W-1:0] wr_data, rd_data;
  logic [BW-1:0]    rd_start;
  logic [SW-1:0]    rd_size;
  logic [ADD_W-1:0] rem_start;

  assign rd_start  = rd_data[SW +: BW];
  assign rd_size   = rd_data[SW-1:0];
  assign rem_start = ADD_W'(rd_start) + ADD_W'(req_r);

  wfba_extent_ram #(
    .DEPTH (MAX_FREE_EXTENTS),
    .WIDTH (ENT_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_stall = (state_r != wfba_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wfba_pkg::S_IDLE;
      count_r <= '0;
      head_r  <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      head_r  <= head_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    req_r        <= req_nxt;
    new_start_r  <= new_start_nxt;
    new_size_r   <= new_size_nxt;
    res_status_r <= res_status_nxt;
    res_start_r  <= res_start_nxt;
    res_blocks_r <= res_blocks_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    head_nxt       = head_r;
    idx_nxt        = idx_r;
    req_nxt        = req_r;
    new_start_nxt  = new_start_r;
    new_size_nxt   = new_size_r;
    res_status_nxt = res_status_r;
    res_start_nxt  = res_start_r;
    res_blocks_nxt = res_blocks_r;
    rd_en          = 1'b0;
    rd_addr        = '0;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = '0;
    load_out       = 1'b0;

    unique case (state_r)
      wfba_pkg::S_IDLE: begin
        if (in_valid) begin
          req_nxt        = in_block_count;
          res_status_nxt = wfba_pkg::ST_OK;
          res_start_nxt  = '0;
          res_blocks_nxt = '0;
          priority if (in_block_count == '0) begin
            res_status_nxt = wfba_pkg::ST_BAD_REQUEST;
            state_nxt      = wfba_pkg::S_DONE;
          end else if (!in_action) begin
            if (count_r == '0) begin
              res_status_nxt = wfba_pkg::ST_NO_REGION;
              state_nxt      = wfba_pkg::S_DONE;
            end else begin
              rd_en     = 1'b1;
              rd_addr   = head_r;
              state_nxt = wfba_pkg::S_HEAD;
            end
          end else if (count_r >= CNT_W'(MAX_FREE_EXTENTS)) begin
            res_status_nxt = wfba_pkg::ST_TABLE_FULL;
            state_nxt      = wfba_pkg::S_DONE;
          end else begin
            new_start_nxt = in_start_block;
            new_size_nxt  = in_block_count;
            idx_nxt       = count_r;
            state_nxt     = wfba_pkg::S_INS;
          end
        end
      end

      wfba_pkg::S_HEAD: begin
        if (rd_size <= req_r) begin
          res_status_nxt = wfba_pkg::ST_OUT_OF_MEMORY;
          state_nxt      = wfba_pkg::S_DONE;
        end else begin
          res_start_nxt  = rd_start;
          res_blocks_nxt = req_r;
          // drop the head, then reinsert the remainder
          new_start_nxt  = rem_start[BW-1:0];
          new_size_nxt   = rd_size - req_r;
          head_nxt       = (head_r == PTR_W'(MAX_FREE_EXTENTS - 1)) ? '0 : head_r + 1'b1;
          count_nxt      = count_r - 1'b1;
          idx_nxt        = count_r - 1'b1;
          state_nxt      = wfba_pkg::S_INS;
        end
      end

      wfba_pkg::S_INS: begin
        if (idx_r == '0) begin
          wr_en     = 1'b1;
          wr_addr   = phys(head_r, '0);
          wr_data   = {new_start_r, new_size_r};
          count_nxt = count_r + 1'b1;
          state_nxt = wfba_pkg::S_DONE;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = phys(head_r, idx_r - 1'b1);
          state_nxt = wfba_pkg::S_CMP;
        end
      end

      // rd_data holds slot idx-1; entries not larger than the new one move down
      wfba_pkg::S_CMP: begin
        if (rd_size <= new_size_r) begin
          wr_en   = 1'b1;
          wr_addr = phys(head_r, idx_r);
          wr_data = rd_data;
          idx_nxt = idx_r - 1'b1;
          if (idx_r > CNT_W'(1)) begin
            rd_en   = 1'b1;
            rd_addr = phys(head_r, idx_r - CNT_W'(2));
          end else begin
            state_nxt = wfba_pkg::S_PUT;
          end
        end else begin
          state_nxt = wfba_pkg::S_PUT;
        end
      end

      wfba_pkg::S_PUT: begin
        wr_en     = 1'b1;
        wr_addr   = phys(head_r, idx_r);
        wr_data   = {new_start_r, new_size_r};
        count_nxt = count_r + 1'b1;
        state_nxt = wfba_pkg::S_DONE;
      end

      wfba_pkg::S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          load_out  = 1'b1;
          state_nxt = wfba_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = wfba_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status_r        <= res_status_r;
      out_region_start_r  <= res_start_r;
      out_region_blocks_r <= res_blocks_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_region_start  = out_region_start_r;
  assign out_region_blocks = out_region_blocks_r;

  // Table never holds more extents than it has slots.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_FREE_EXTENTS))
    else $error("extent count above table depth");

  // The pipelined shift walk must never read the slot it writes.
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("read and write of the same extent slot");

  // A failed or add word carries no region.
  a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_region_blocks_r == '0) |-> (out_region_start_r == '0))
    else $error("region start without region blocks");

  // Results are loaded only when the output register is free or draining.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (!out_valid_r || !out_stall))
    else $error("output word overwritten while stalled");

endmodule

`default_nettype wire

@@ src/wfba_extent_ram.sv @@
// Single-port-write, single-port-read extent memory with registered read data.
// Standalone; used by worst_fit_block_allocator_core.
`default_nettype none

module wfba_extent_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 33
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire
